/* design/quaternion_slerp_macros.svh */
// ----------------------------------------------------------------------------
// quaternion_slerp_macros
// assertion macros for the quaternion slerp pipeline
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_MACROS_SVH
`define QUATERNION_SLERP_MACROS_SVH
`ifndef SYNTHESIS
`define QS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define QS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define QS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/qslerp_pkg.sv */
// ----------------------------------------------------------------------------
// qslerp_pkg
// shared constants and angle table of the quaternion slerp pipeline
// ----------------------------------------------------------------------------
package qslerp_pkg;
   localparam int FRAC_BITS_DEF    = 14;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANG_LEN          = 32;
   localparam logic [14:0] THRESH_RESET = 15'd16368;
   localparam logic [16:0] BLEND_ONE    = 17'd32768;
   localparam logic [0:0]  REG_THRESH   = 1'b0;

   function automatic logic signed [33:0] atan_rom(input int i);
      logic signed [33:0] r;
      case (i)
         0: r = 34'sd843314857;  1: r = 34'sd497837829;  2: r = 34'sd263043837;
         3: r = 34'sd133525159;  4: r = 34'sd67021687;   5: r = 34'sd33543516;
         6: r = 34'sd16775851;   7: r = 34'sd8388437;    8: r = 34'sd4194283;
         9: r = 34'sd2097149;    10: r = 34'sd1048576;   11: r = 34'sd524288;
         12: r = 34'sd262144;    13: r = 34'sd131072;    14: r = 34'sd65536;
         15: r = 34'sd32768;     16: r = 34'sd16384;     17: r = 34'sd8192;
         18: r = 34'sd4096;      19: r = 34'sd2048;      20: r = 34'sd1024;
         21: r = 34'sd512;       22: r = 34'sd256;       23: r = 34'sd128;
         24: r = 34'sd64;        25: r = 34'sd32;        26: r = 34'sd16;
         27: r = 34'sd8;         28: r = 34'sd4;         29: r = 34'sd2;
         30: r = 34'sd1;         31: r = 34'sd0;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction
endpackage

/* design/quaternion_slerp.sv */
// ----------------------------------------------------------------------------
// quaternion_slerp
// pipelined fixed-point spherical interpolation of two quaternions
// ----------------------------------------------------------------------------
// usage: drive req_ fields with start high; busy is always low, so one beat
// may enter every cycle. each result appears on rsp_ ports for one cycle
// with rsp_valid high, in order. the steps are: products; dot, sign fix
// and threshold; cos; square of cos; square root (load and 32 stages, one
// result bit each); vectoring cordic; angle products; rotation cordic
// (three lanes); weight setup; two dividers (one bit per stage); weight
// select, blend multiply, round and saturate.
// throughput is one beat per clock, set by the fully staged pipeline;
// each square root, cordic and divider step is one register stage.
// the receiver cannot stall; results are never held back.
// reset (synchronous, active high) clears all valid bits and sets
// linear_threshold to 16368. the csr_ port is apb style, pready is always
// high, register 0 at address 0 holds linear_threshold (15 bits).
// the user must write configuration only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "quaternion_slerp_macros.svh"
module quaternion_slerp #(
   parameter int FRAC_BITS    = qslerp_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_a_x,
   input  logic signed [15:0] req_a_y,
   input  logic signed [15:0] req_a_z,
   input  logic signed [15:0] req_a_w,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_b_z,
   input  logic signed [15:0] req_b_w,
   input  logic        [15:0] req_blend,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic signed [15:0] rsp_out_w,
   output logic               rsp_took_linear,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic        [2:0]  csr_paddr,
   input  logic        [31:0] csr_pwdata,
   output logic        [31:0] csr_prdata,
   output logic               csr_pready
);
   localparam int NS  = (CORDIC_STEPS > qslerp_pkg::ANG_LEN) ? qslerp_pkg::ANG_LEN
                                                             : CORDIC_STEPS;
   localparam int SH  = 2 * FRAC_BITS - 30;
   localparam int DW  = 2 * FRAC_BITS + 18;   // dot magnitude width
   localparam int SQ  = 32;                   // sqrt stages (2 bits each)
   localparam int DV  = 30;                   // divider quotient bits
   localparam int CW  = 34;                   // cordic data width

   typedef logic signed [16:0] comp_type [4];

   // ---------------- csr ----------------
   logic [14:0] thresh_ff;
   logic        csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= qslerp_pkg::THRESH_RESET;
      end else if (csr_wr && (csr_paddr[2] == qslerp_pkg::REG_THRESH)) begin
         thresh_ff <= csr_pwdata[14:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == qslerp_pkg::REG_THRESH) ? {17'd0, thresh_ff} : 32'd0;
   assign busy = 1'b0;

   // ---------------- stage 0: products ----------------
   logic              v0_ff;
   comp_type          a0_ff, b0_ff;
   logic signed [31:0] p0_ff [4];
   logic [16:0]       t0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start;
      a0_ff <= '{17'(req_a_x), 17'(req_a_y), 17'(req_a_z), 17'(req_a_w)};
      b0_ff <= '{17'(req_b_x), 17'(req_b_y), 17'(req_b_z), 17'(req_b_w)};
      p0_ff[0] <= req_a_x * req_b_x;
      p0_ff[1] <= req_a_y * req_b_y;
      p0_ff[2] <= req_a_z * req_b_z;
      p0_ff[3] <= req_a_w * req_b_w;
      t0_ff <= ({1'b0, req_blend} > qslerp_pkg::BLEND_ONE) ? qslerp_pkg::BLEND_ONE
                                                            : {1'b0, req_blend};
   end

   // ---------------- stage 1: dot, sign fix, threshold ----------------
   logic signed [33:0] dot_c;
   assign dot_c = 34'(p0_ff[0]) + 34'(p0_ff[1]) + 34'(p0_ff[2]) + 34'(p0_ff[3]);
   logic              v1_ff, lin1_ff;
   comp_type          a1_ff, b1_ff;
   logic [16:0]       t1_ff;
   logic [DW-1:0]     d1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      for (int i = 0; i < 4; i++) begin
         a1_ff[i] <= dot_c[33] ? -a0_ff[i] : a0_ff[i];
      end
      b1_ff <= b0_ff;
      t1_ff <= t0_ff;
      d1_ff <= DW'(dot_c[33] ? -dot_c : dot_c);
      lin1_ff <= (DW'(dot_c[33] ? -dot_c : dot_c)) > (DW'(thresh_ff) << FRAC_BITS);
   end

   // ---------------- stage 2: cos in q30 ----------------
   logic [DW+31:0] cext;
   assign cext = (SH > 0) ? ((DW+32)'(d1_ff) >> (SH > 0 ? SH : 0))
                          : ((DW+32)'(d1_ff) << (SH > 0 ? 0 : -SH));
   logic              v2_ff, lin2_ff;
   comp_type          a2_ff, b2_ff;
   logic [16:0]       t2_ff;
   logic [30:0]       c2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      a2_ff <= a1_ff; b2_ff <= b1_ff; t2_ff <= t1_ff;
      lin2_ff <= lin1_ff || (cext >= (DW+32)'(64'd1 << 30));
      c2_ff <= cext[30:0];
   end

   // stage 3: square of cos
   logic              v3_ff, lin3_ff;
   comp_type          a3_ff, b3_ff;
   logic [16:0]       t3_ff;
   logic [30:0]       c3_ff;
   logic [61:0]       cc3_ff;
   logic [30:0]       c2m;
   assign c2m = lin2_ff ? 31'd0 : c2_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      a3_ff <= a2_ff; b3_ff <= b2_ff; t3_ff <= t2_ff; lin3_ff <= lin2_ff;
      c3_ff <= c2m;
      cc3_ff <= 62'({31'd0, c2m[30:15]} * c2m) << 15;
   end
   logic [61:0] cclo;
   assign cclo = 62'(c3_ff[14:0] * c3_ff);

   // ---------------- sqrt pipeline ----------------
   logic              sv_ff  [SQ+1];
   logic              sl_ff  [SQ+1];
   comp_type          sa_ff  [SQ+1];
   comp_type          sb_ff  [SQ+1];
   logic [16:0]       st_ff  [SQ+1];
   logic [30:0]       sc_ff  [SQ+1];
   logic [63:0]       srem_ff[SQ+1];
   logic [63:0]       sres_ff[SQ+1];
   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else       sv_ff[0] <= v3_ff;
      sl_ff[0] <= lin3_ff; sa_ff[0] <= a3_ff; sb_ff[0] <= b3_ff;
      st_ff[0] <= t3_ff; sc_ff[0] <= c3_ff;
      srem_ff[0] <= (64'd1 << 60) - 64'(cc3_ff + cclo);
      sres_ff[0] <= 64'd0;
   end
   for (genvar g = 0; g < SQ; g++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
      logic [63:0] trial;
      assign trial = sres_ff[g] + BIT;
      always_ff @(posedge clock) begin
         if (reset) sv_ff[g+1] <= 1'b0;
         else       sv_ff[g+1] <= sv_ff[g];
         sl_ff[g+1] <= sl_ff[g]; sa_ff[g+1] <= sa_ff[g]; sb_ff[g+1] <= sb_ff[g];
         st_ff[g+1] <= st_ff[g]; sc_ff[g+1] <= sc_ff[g];
         if (srem_ff[g] >= trial) begin
            srem_ff[g+1] <= srem_ff[g] - trial;
            sres_ff[g+1] <= (sres_ff[g] >> 1) + BIT;
         end else begin
            srem_ff[g+1] <= srem_ff[g];
            sres_ff[g+1] <= sres_ff[g] >> 1;
         end
      end
   end

   // ---------------- vectoring cordic ----------------
   logic              vv_ff [NS+1];
   logic              vl_ff [NS+1];
   comp_type          va_ff [NS+1];
   comp_type          vb_ff [NS+1];
   logic [16:0]       vt_ff [NS+1];
   logic signed [CW-1:0] vx_ff [NS+1];
   logic signed [CW-1:0] vy_ff [NS+1];
   logic signed [CW-1:0] vz_ff [NS+1];
   always_comb begin
      vv_ff[0] = sv_ff[SQ]; vl_ff[0] = sl_ff[SQ]; va_ff[0] = sa_ff[SQ];
      vb_ff[0] = sb_ff[SQ]; vt_ff[0] = st_ff[SQ];
      vx_ff[0] = CW'(sc_ff[SQ]); vy_ff[0] = CW'(sres_ff[SQ][31:0]); vz_ff[0] = '0;
   end
   for (genvar g = 0; g < NS; g++) begin : g_vec
      localparam logic signed [CW-1:0] ANG = qslerp_pkg::atan_rom(g);
      always_ff @(posedge clock) begin
         if (reset) vv_ff[g+1] <= 1'b0;
         else       vv_ff[g+1] <= vv_ff[g];
         vl_ff[g+1] <= vl_ff[g]; va_ff[g+1] <= va_ff[g]; vb_ff[g+1] <= vb_ff[g];
         vt_ff[g+1] <= vt_ff[g];
         if (vy_ff[g] > 0) begin
            vx_ff[g+1] <= vx_ff[g] + (vy_ff[g] >>> g);
            vy_ff[g+1] <= vy_ff[g] - (vx_ff[g] >>> g);
            vz_ff[g+1] <= vz_ff[g] + ANG;
         end else begin
            vx_ff[g+1] <= vx_ff[g] - (vy_ff[g] >>> g);
            vy_ff[g+1] <= vy_ff[g] + (vx_ff[g] >>> g);
            vz_ff[g+1] <= vz_ff[g] - ANG;
         end
      end
   end

   // ---------------- angle products ----------------
   logic signed [CW-1:0] om;
   assign om = vz_ff[NS][CW-1] ? '0 : vz_ff[NS];
   logic              mv_ff, ml_ff;
   comp_type          ma_ff, mb_ff;
   logic [16:0]       mt_ff;
   logic signed [CW-1:0] mz_ff [3];
   always_ff @(posedge clock) begin
      if (reset) mv_ff <= 1'b0;
      else       mv_ff <= vv_ff[NS];
      ml_ff <= vl_ff[NS]; ma_ff <= va_ff[NS]; mb_ff <= vb_ff[NS]; mt_ff <= vt_ff[NS];
      mz_ff[0] <= om;
      mz_ff[1] <= CW'((49'(qslerp_pkg::BLEND_ONE - vt_ff[NS]) * 49'(om[31:0])) >> 15);
      mz_ff[2] <= CW'((49'(vt_ff[NS]) * 49'(om[31:0])) >> 15);
   end

   // ---------------- rotation cordic, three lanes ----------------
   logic              rv_ff [NS+1];
   logic              rl_ff [NS+1];
   comp_type          ra_ff [NS+1];
   comp_type          rb_ff [NS+1];
   logic [16:0]       rt_ff [NS+1];
   logic signed [CW-1:0] rx_ff [NS+1][3];
   logic signed [CW-1:0] ry_ff [NS+1][3];
   logic signed [CW-1:0] rz_ff [NS+1][3];
   always_comb begin
      rv_ff[0] = mv_ff; rl_ff[0] = ml_ff; ra_ff[0] = ma_ff; rb_ff[0] = mb_ff;
      rt_ff[0] = mt_ff;
      for (int k = 0; k < 3; k++) begin
         rx_ff[0][k] = CW'(64'd1 << 30); ry_ff[0][k] = '0; rz_ff[0][k] = mz_ff[k];
      end
   end
   for (genvar g = 0; g < NS; g++) begin : g_rot
      localparam logic signed [CW-1:0] ANG = qslerp_pkg::atan_rom(g);
      always_ff @(posedge clock) begin
         if (reset) rv_ff[g+1] <= 1'b0;
         else       rv_ff[g+1] <= rv_ff[g];
         rl_ff[g+1] <= rl_ff[g]; ra_ff[g+1] <= ra_ff[g]; rb_ff[g+1] <= rb_ff[g];
         rt_ff[g+1] <= rt_ff[g];
         for (int k = 0; k < 3; k++) begin
            if (!rz_ff[g][k][CW-1]) begin
               rx_ff[g+1][k] <= rx_ff[g][k] - (ry_ff[g][k] >>> g);
               ry_ff[g+1][k] <= ry_ff[g][k] + (rx_ff[g][k] >>> g);
               rz_ff[g+1][k] <= rz_ff[g][k] - ANG;
            end else begin
               rx_ff[g+1][k] <= rx_ff[g][k] + (ry_ff[g][k] >>> g);
               ry_ff[g+1][k] <= ry_ff[g][k] - (rx_ff[g][k] >>> g);
               rz_ff[g+1][k] <= rz_ff[g][k] + ANG;
            end
         end
      end
   end

   // ---------------- weight setup ----------------
   logic signed [CW-1:0] den_c, n0_c, n1_c;
   assign den_c = ry_ff[NS][0];
   assign n0_c  = ry_ff[NS][1];
   assign n1_c  = ry_ff[NS][2];
   logic              wv_ff, wl_ff;
   comp_type          wa_ff, wb_ff;
   logic [16:0]       wt_ff;
   logic [1:0]        wsat_ff [2];   // [1]=force one, [0]=force zero
   logic [32:0]       wden_ff;
   logic [32:0]       wn_ff [2];
   always_ff @(posedge clock) begin
      if (reset) wv_ff <= 1'b0;
      else       wv_ff <= rv_ff[NS];
      wl_ff <= rl_ff[NS] || (den_c <= 0);
      wa_ff <= ra_ff[NS]; wb_ff <= rb_ff[NS]; wt_ff <= rt_ff[NS];
      wden_ff <= 33'(den_c);
      wn_ff[0] <= 33'(n0_c); wn_ff[1] <= 33'(n1_c);
      wsat_ff[0] <= {(n0_c > 0) && (n0_c >= den_c), n0_c <= 0};
      wsat_ff[1] <= {(n1_c > 0) && (n1_c >= den_c), n1_c <= 0};
   end

   // ---------------- restoring dividers, one bit per stage ----------------
   logic              dv_ff [DV+1];
   logic              dl_ff [DV+1];
   comp_type          da_ff [DV+1];
   comp_type          db_ff [DV+1];
   logic [16:0]       dt_ff [DV+1];
   logic [1:0]        ds_ff [DV+1][2];
   logic [32:0]       dd_ff [DV+1];
   logic [32:0]       dr_ff [DV+1][2];
   logic [30:0]       dq_ff [DV+1][2];
   always_comb begin
      dv_ff[0] = wv_ff; dl_ff[0] = wl_ff; da_ff[0] = wa_ff; db_ff[0] = wb_ff;
      dt_ff[0] = wt_ff; dd_ff[0] = wden_ff;
      for (int k = 0; k < 2; k++) begin
         ds_ff[0][k] = wsat_ff[k]; dr_ff[0][k] = wn_ff[k]; dq_ff[0][k] = '0;
      end
   end
   for (genvar g = 0; g < DV; g++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) dv_ff[g+1] <= 1'b0;
         else       dv_ff[g+1] <= dv_ff[g];
         dl_ff[g+1] <= dl_ff[g]; da_ff[g+1] <= da_ff[g]; db_ff[g+1] <= db_ff[g];
         dt_ff[g+1] <= dt_ff[g]; dd_ff[g+1] <= dd_ff[g];
         for (int k = 0; k < 2; k++) begin
            ds_ff[g+1][k] <= ds_ff[g][k];
            if ({dr_ff[g][k], 1'b0} >= {1'b0, dd_ff[g]}) begin
               dr_ff[g+1][k] <= 33'({dr_ff[g][k], 1'b0} - {1'b0, dd_ff[g]});
               dq_ff[g+1][k] <= {dq_ff[g][k][29:0], 1'b1};
            end else begin
               dr_ff[g+1][k] <= {dr_ff[g][k][31:0], 1'b0};
               dq_ff[g+1][k] <= {dq_ff[g][k][29:0], 1'b0};
            end
         end
      end
   end

   // ---------------- weight select ----------------
   function automatic logic [30:0] pick(input logic [1:0] s, input logic [30:0] q);
      logic [30:0] r;
      if (s[0])      r = 31'd0;
      else if (s[1]) r = 31'd1 << 30;
      else           r = q;
      return r;
   endfunction
   logic              kv_ff, kl_ff;
   comp_type          ka_ff, kb_ff;
   logic [30:0]       k0_ff, k1_ff;
   always_ff @(posedge clock) begin
      if (reset) kv_ff <= 1'b0;
      else       kv_ff <= dv_ff[DV];
      kl_ff <= dl_ff[DV]; ka_ff <= da_ff[DV]; kb_ff <= db_ff[DV];
      if (dl_ff[DV]) begin
         k0_ff <= 31'(qslerp_pkg::BLEND_ONE - dt_ff[DV]) << 15;
         k1_ff <= 31'(dt_ff[DV]) << 15;
      end else begin
         k0_ff <= pick(ds_ff[DV][0], dq_ff[DV][0]);
         k1_ff <= pick(ds_ff[DV][1], dq_ff[DV][1]);
      end
   end

   // ---------------- blend products ----------------
   logic              bv_ff, bl_ff;
   logic signed [47:0] pa_ff [4];
   logic signed [47:0] pb_ff [4];
   always_ff @(posedge clock) begin
      if (reset) bv_ff <= 1'b0;
      else       bv_ff <= kv_ff;
      bl_ff <= kl_ff;
      for (int i = 0; i < 4; i++) begin
         pa_ff[i] <= 48'(ka_ff[i]) * 48'(signed'({1'b0, k0_ff}));
         pb_ff[i] <= 48'(kb_ff[i]) * 48'(signed'({1'b0, k1_ff}));
      end
   end

   // ---------------- round, saturate ----------------
   logic signed [48:0] sum_c [4];
   logic signed [18:0] sh_c  [4];
   logic               ov_ff, ol_ff;
   logic signed [15:0] o_ff [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum_c[i] = 49'(pa_ff[i]) + 49'(pb_ff[i]) + 49'sd536870912;
         sh_c[i]  = 19'(sum_c[i] >>> 30);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= bv_ff;
      ol_ff <= bl_ff;
      for (int i = 0; i < 4; i++) begin
         if (sh_c[i] > 19'sd32767)       o_ff[i] <= 16'sh7fff;
         else if (sh_c[i] < -19'sd32768) o_ff[i] <= 16'sh8000;
         else                            o_ff[i] <= sh_c[i][15:0];
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_x       = o_ff[0];
   assign rsp_out_y       = o_ff[1];
   assign rsp_out_z       = o_ff[2];
   assign rsp_out_w       = o_ff[3];
   assign rsp_took_linear = ol_ff;

   `QS_ASSERT_NEXT(a_valid_flow, clock, reset, bv_ff, ov_ff)
   `QS_ASSERT_NEXT(a_kvalid_flow, clock, reset, kv_ff, bv_ff)
   `QS_ASSERT_IMPL(a_lin_weights, clock, reset, kv_ff && kl_ff,
      (33'(k0_ff) + 33'(k1_ff)) == (33'd1 << 30))
   `QS_ASSERT_IMPL(a_weight_range, clock, reset, kv_ff,
      (k0_ff <= (31'd1 << 30)) && (k1_ff <= (31'd1 << 30)))
endmodule

/* test/slerp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slerp_checker
// watches the request and result channels of the slerp block, predicts each
// blended quaternion in fixed point and compares results in request order
// ----------------------------------------------------------------------------
module slerp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_a_x,
   input  logic signed [15:0] req_a_y,
   input  logic signed [15:0] req_a_z,
   input  logic signed [15:0] req_a_w,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_b_z,
   input  logic signed [15:0] req_b_w,
   input  logic        [15:0] req_blend,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_out_x,
   input  logic signed [15:0] rsp_out_y,
   input  logic signed [15:0] rsp_out_z,
   input  logic signed [15:0] rsp_out_w,
   input  logic               rsp_took_linear,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic        [2:0]  csr_paddr,
   input  logic        [31:0] csr_pwdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending
);
   typedef struct packed {
      logic signed [15:0] x, y, z, w;
      logic               lin;
   } pred_type;

   localparam longint ONE_Q30 = 64'sd1 << 30;

   pred_type    blend_q[$];
   logic [14:0] thresh;

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint vec_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < qslerp_pkg::CORDIC_STEPS_DEF; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += qslerp_pkg::atan_rom(i);
         end else begin
            x -= dx; y += dy; z -= qslerp_pkg::atan_rom(i);
         end
      end
      return z;
   endfunction

   function automatic longint rot_sine(longint z);
      longint x, y, dx, dy;
      x = ONE_Q30;
      y = 0;
      for (int i = 0; i < qslerp_pkg::CORDIC_STEPS_DEF; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= qslerp_pkg::atan_rom(i);
         end else begin
            x += dx; y -= dy; z += qslerp_pkg::atan_rom(i);
         end
      end
      return y;
   endfunction

   function automatic longint arc_weight(longint num, longint den);
      longint w;
      if (num <= 0) return 0;
      if (num >= den) return ONE_Q30;
      w = (num <<< 30) / den;
      return w > ONE_Q30 ? ONE_Q30 : w;
   endfunction

   function automatic pred_type slerp(longint a[4], longint b[4], longint t,
                                      logic [14:0] th);
      pred_type r;
      longint dot, k0, k1, c, s, om, den, v;
      logic   lin;
      dot = 0;
      for (int i = 0; i < 4; i++) dot += a[i] * b[i];
      if (dot < 0) begin
         for (int i = 0; i < 4; i++) a[i] = -a[i];
         dot = -dot;
      end
      if (t > 32768) t = 32768;
      lin = dot > (longint'(th) <<< 14);
      k0 = 0;
      k1 = 0;
      if (!lin) begin
         c = dot <<< 2;
         if (c >= ONE_Q30) begin
            lin = 1;
         end else begin
            s = int_sqrt((64'd1 << 60) - c * c);
            om = vec_angle(c, s);
            if (om < 0) om = 0;
            den = rot_sine(om);
            if (den <= 0) begin
               lin = 1;
            end else begin
               k0 = arc_weight(rot_sine(fshift((32768 - t) * om, 15)), den);
               k1 = arc_weight(rot_sine(fshift(t * om, 15)), den);
            end
         end
      end
      if (lin) begin
         k0 = (32768 - t) <<< 15;
         k1 = t <<< 15;
      end
      for (int i = 0; i < 4; i++) begin
         v = fshift(a[i] * k0 + b[i] * k1 + (64'sd1 << 29), 30);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         case (i)
            0: r.x = v[15:0];
            1: r.y = v[15:0];
            2: r.z = v[15:0];
            default: r.w = v[15:0];
         endcase
      end
      r.lin = lin;
      return r;
   endfunction

   assign pending = blend_q.size();

   always @(posedge clock) begin
      longint a[4], b[4];
      pred_type e;
      if (reset) begin
         thresh <= qslerp_pkg::THRESH_RESET;
         blend_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == qslerp_pkg::REG_THRESH)
            thresh <= csr_pwdata[14:0];
         if (rsp_valid) begin
            if (blend_q.size() == 0) begin
               $error("unexpected result beat");
               fail_count <= fail_count + 1;
            end else begin
               e = blend_q.pop_front();
               if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_z !== e.z
                   || rsp_out_w !== e.w || rsp_took_linear !== e.lin)
                  fail_count <= fail_count + 1;
               if (rsp_out_x !== e.x)
                  $error("out_x expected %0d actual %0d", e.x, rsp_out_x);
               if (rsp_out_y !== e.y)
                  $error("out_y expected %0d actual %0d", e.y, rsp_out_y);
               if (rsp_out_z !== e.z)
                  $error("out_z expected %0d actual %0d", e.z, rsp_out_z);
               if (rsp_out_w !== e.w)
                  $error("out_w expected %0d actual %0d", e.w, rsp_out_w);
               if (rsp_took_linear !== e.lin)
                  $error("took_linear expected %0d actual %0d", e.lin,
                         rsp_took_linear);
            end
         end
         if (start && !busy) begin
            a[0] = req_a_x; a[1] = req_a_y; a[2] = req_a_z; a[3] = req_a_w;
            b[0] = req_b_x; b[1] = req_b_y; b[2] = req_b_z; b[3] = req_b_w;
            blend_q.push_back(slerp(a, b, longint'(req_blend), thresh));
         end
      end
   end
endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives quaternion pairs and threshold settings into the slerp pipeline
// under several idling patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
   logic clock = 0, reset = 1, start = 0, busy;
   logic signed [15:0] a_x = 0, a_y = 0, a_z = 0, a_w = 0;
   logic signed [15:0] b_x = 0, b_y = 0, b_z = 0, b_w = 0;
   logic [15:0] blend = 0;
   logic rsp_valid, rsp_took_linear, csr_pready;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   int fail_count, pending;
   int idle_pct;

   localparam int DRAIN = 200;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   quaternion_slerp u_top (
      .clock, .reset, .start, .busy,
      .req_a_x(a_x), .req_a_y(a_y), .req_a_z(a_z), .req_a_w(a_w),
      .req_b_x(b_x), .req_b_y(b_y), .req_b_z(b_z), .req_b_w(b_w),
      .req_blend(blend),
      .rsp_valid, .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_out_w, .rsp_took_linear,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   slerp_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_a_x(a_x), .req_a_y(a_y), .req_a_z(a_z), .req_a_w(a_w),
      .req_b_x(b_x), .req_b_y(b_y), .req_b_z(b_z), .req_b_w(b_w),
      .req_blend(blend),
      .rsp_valid, .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_out_w, .rsp_took_linear,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .pending
   );

   // one beat, held until accepted; idles before it at the current rate
   task automatic send(logic signed [15:0] ax, ay, az, aw, bx, by, bz, bw,
                       logic [15:0] t);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
      b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
      blend <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic write_thresh(logic [14:0] v);
      drain();
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= 3'd4 * qslerp_pkg::REG_THRESH;
      csr_pwdata <= 32'(v);
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] comp();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'(16384 - $urandom_range(1) * 32768);
      if (r == 1) return 16'($urandom);
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   function automatic logic [15:0] rand_blend();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'($urandom);
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   // nearby pair (second possibly negated) with a controlled angle
   task automatic send_near();
      logic signed [15:0] q[4], p[4];
      int d, s;
      s = $urandom_range(1) ? -1 : 1;
      for (int i = 0; i < 4; i++) q[i] = 16'($signed($urandom_range(16000)) - 8000);
      d = $urandom_range(3) == 0 ? $urandom_range(20) : $urandom_range(3000);
      for (int i = 0; i < 4; i++)
         p[i] = 16'(s * (q[i] + $signed($urandom_range(2 * d)) - d));
      send(q[0], q[1], q[2], q[3], p[0], p[1], p[2], p[3], rand_blend());
   endtask

   logic [14:0] th_list[6] = '{15'd0, 15'd16384, 15'd32767, 15'd8000, 15'd16000,
                               qslerp_pkg::THRESH_RESET};
   int pct_list[4] = '{0, 61, 0, 10};

   initial begin
      #2_000_000;
      $display("** quaternion_slerp: FAILED **");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      idle_pct = 0;
      // extremes, identical, opposite, orthogonal, non-unit, blend above one
      send(16384, 0, 0, 0, 16384, 0, 0, 0, 0);
      send(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
      send(16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
      send(16384, 0, 0, 0, 0, 16384, 0, 0, 16384);
      send(0, 0, 16384, 0, 0, 0, 0, 16384, 32768);
      send(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, 9000);
      send(16384, 16384, 16384, 16384, -16384, 16384, -16384, 16384, 65535);
      send(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 12345);
      send(11585, 11585, 0, 0, 16384, 0, 0, 0, 20000);
      send(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8190, 16384);
      send(0, 0, 0, 0, 0, 0, 0, 0, 40000);
      send(16384, 0, 0, 0, 16383, 181, 0, 0, 32767);
      send(-1, 1, -1, 1, 1, 1, 1, 1, 1);
      for (int ph = 0; ph < 6; ph++) begin
         write_thresh(th_list[ph]);
         idle_pct = pct_list[ph % 4];
         for (int n = 0; n < 100; n++) begin
            if (n == 50 && ph == 1) drain();
            if ($urandom_range(3) == 0)
               send(comp(), comp(), comp(), comp(), comp(), comp(), comp(), comp(),
                    rand_blend());
            else
               send_near();
         end
      end
      drain();
      if (fail_count == 0)
         $display("** quaternion_slerp: PASSED **");
      else
         $display("** quaternion_slerp: FAILED **");
      $finish;
   end
endmodule
